[sv/rth_pkg.sv]
// ---------------------------------------------------------------------------
// rth_pkg: shared definitions for the ray / triangle hit test
// Register indexes, fixed field widths and the default coordinate width.
// ---------------------------------------------------------------------------
package rth_pkg;

	// default coordinate width in bits
	localparam int RTH_COORD_BITS = 16;

	// threshold register width
	localparam int EPS_BITS = 41;

	// triangle tag width
	localparam int TAG_BITS = 16;

	// configuration port shape
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = EPS_BITS;

	// result beat: hit flag, then tag, padded to whole bytes
	localparam int OUT_BITS = ((1 + TAG_BITS + 7) / 8) * 8;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_EPSILON  = 3'd6
	} cfg_reg_t;

endpackage

[sv/ray_triangle_hit_test_top.sv]
// ---------------------------------------------------------------------------
// ray_triangle_hit_test_top: pipelined ray / triangle hit test
// Exact integer Moller-Trumbore test of one triangle per beat against a ray
// held in configuration registers.
// ---------------------------------------------------------------------------
// Usage
// - input stream s_*: one triangle per beat, v0..v2 coordinates and a tag
// - output stream m_*: one result per input beat, hit flag and the tag
// - cfg_*: ray origin, ray direction and threshold, written while idle
// Pipeline: eight register stages (edges, cross terms, cross, dot terms, sums,
//   sign fold, v sum, final compares) lie between an accepted input beat and
//   its result beat.
// Throughput: one triangle per cycle while the output is taken.
// Stall: all stages advance together when the last stage is empty or its
//   beat is taken; a one-entry skid register on the input catches a beat
//   arriving during a stall, so s_tready is a register output.
// Reset: arst_n clears all valid bits and the skid entry, loads origin 0,
//   direction (0,0,1) and threshold 1.
// ---------------------------------------------------------------------------
module ray_triangle_hit_test_top
	import rth_pkg::*;
#(
	parameter int COORD_BITS = RTH_COORD_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// configuration write port
	input  logic                                      cfg_we,
	input  logic [CFG_ADDR_BITS-1:0]                  cfg_addr,
	input  logic [CFG_DATA_BITS-1:0]                  cfg_wdata,
	// input stream
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// s_tdata from bit 0: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y,
	// v2_z (COORD_BITS each), tri_tag (16), zero padding
	input  logic [((9*COORD_BITS+TAG_BITS+7)/8)*8-1:0] s_tdata,
	// output stream
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// m_tdata from bit 0: hit (1), hit_tag (16), zero padding
	output logic [OUT_BITS-1:0]                       m_tdata
);

	localparam int C    = COORD_BITS;
	localparam int IN_W = ((9*C + TAG_BITS + 7) / 8) * 8;
	localparam int EW   = C + 1;          // edges and t
	localparam int PPW  = 2*C + 1;        // dir x e2 terms
	localparam int PW   = 2*C + 2;        // p
	localparam int QPW  = 2*C + 2;        // t x e1 terms
	localparam int QW   = 2*C + 3;        // q
	localparam int DPW  = 3*C + 3;        // dot product terms
	localparam int W    = (3*C + 6 > EPS_BITS + 1) ? 3*C + 6 : EPS_BITS + 1;

	// configuration registers
	logic signed [C-1:0]        org_q [3];
	logic signed [C-1:0]        dir_q [3];
	logic        [EPS_BITS-1:0] eps_q;
	logic signed [W-1:0]        eps_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
			end
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= C'(1);
			eps_q    <= EPS_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_ORIGIN_X: org_q[0] <= cfg_wdata[C-1:0];
				REG_ORIGIN_Y: org_q[1] <= cfg_wdata[C-1:0];
				REG_ORIGIN_Z: org_q[2] <= cfg_wdata[C-1:0];
				REG_DIR_X:    dir_q[0] <= cfg_wdata[C-1:0];
				REG_DIR_Y:    dir_q[1] <= cfg_wdata[C-1:0];
				REG_DIR_Z:    dir_q[2] <= cfg_wdata[C-1:0];
				REG_EPSILON:  eps_q    <= cfg_wdata[EPS_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign eps_w = W'(signed'({1'b0, eps_q}));

	// pipeline advance
	logic en;
	logic vld_s8;
	assign en = !vld_s8 || m_tready;

	// input skid entry
	logic            skid_q;
	logic [IN_W-1:0] skid_data_q;
	logic            in_vld;
	logic [IN_W-1:0] in_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (en) begin
			skid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && s_tvalid && s_tready) begin
			skid_data_q <= s_tdata;
		end
	end

	assign s_tready = !skid_q;
	assign in_vld   = skid_q || s_tvalid;
	assign in_data  = skid_q ? skid_data_q : s_tdata;

	// unpack coordinates
	logic signed [C-1:0] v0 [3];
	logic signed [C-1:0] v1 [3];
	logic signed [C-1:0] v2 [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v0[i] = in_data[i*C +: C];
			v1[i] = in_data[(3+i)*C +: C];
			v2[i] = in_data[(6+i)*C +: C];
		end
	end

	// valid bits and payload per stage
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [TAG_BITS-1:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;

	logic signed [EW-1:0]  v0_s1 [3];
	logic signed [EW-1:0]  e1_s1 [3];
	logic signed [EW-1:0]  e2_s1 [3];
	logic signed [PPW-1:0] pp_s2 [6];
	logic signed [EW-1:0]  t_s2  [3];
	logic signed [EW-1:0]  e1_s2 [3];
	logic signed [PW-1:0]  p_s3  [3];
	logic signed [EW-1:0]  t_s3  [3];
	logic signed [EW-1:0]  e1_s3 [3];
	logic signed [DPW-1:0] dp_s4 [3];
	logic signed [DPW-1:0] up_s4 [3];
	logic signed [QPW-1:0] qp_s4 [6];
	logic signed [W-1:0]   det_s5;
	logic signed [W-1:0]   u_s5;
	logic signed [QW-1:0]  q_s5  [3];
	logic signed [DPW-1:0] vp_s6 [3];
	logic signed [W-1:0]   det_s6;
	logic signed [W-1:0]   u_s6;
	logic                  flip_s6;
	logic                  ok_s6;
	logic signed [W-1:0]   det_s7;
	logic signed [W-1:0]   u_s7;
	logic signed [W-1:0]   v_s7;
	logic                  ok_s7;
	logic                  hit_s8;

	// sign fold on the determinant
	logic                flip;
	logic signed [W-1:0] det_f;
	logic signed [W-1:0] u_f;
	logic signed [W-1:0] v_sum;
	assign flip  = !(eps_w < det_s5);
	assign det_f = flip ? -det_s5 : det_s5;
	assign u_f   = flip ? -u_s5 : u_s5;
	assign v_sum = W'(vp_s6[0]) + W'(vp_s6[1]) + W'(vp_s6[2]);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: edges from vertex 0
			for (int i = 0; i < 3; i++) begin
				v0_s1[i] <= EW'(v0[i]);
				e1_s1[i] <= EW'(v1[i]) - EW'(v0[i]);
				e2_s1[i] <= EW'(v2[i]) - EW'(v0[i]);
			end
			tag_s1 <= in_data[9*C +: TAG_BITS];

			// stage 2: dir x e2 terms, t = origin - v0
			pp_s2[0] <= PPW'(dir_q[1]) * PPW'(e2_s1[2]);
			pp_s2[1] <= PPW'(dir_q[2]) * PPW'(e2_s1[1]);
			pp_s2[2] <= PPW'(dir_q[2]) * PPW'(e2_s1[0]);
			pp_s2[3] <= PPW'(dir_q[0]) * PPW'(e2_s1[2]);
			pp_s2[4] <= PPW'(dir_q[0]) * PPW'(e2_s1[1]);
			pp_s2[5] <= PPW'(dir_q[1]) * PPW'(e2_s1[0]);
			for (int i = 0; i < 3; i++) begin
				t_s2[i]  <= EW'(org_q[i]) - v0_s1[i];
				e1_s2[i] <= e1_s1[i];
			end
			tag_s2 <= tag_s1;

			// stage 3: p = dir x e2
			p_s3[0] <= PW'(pp_s2[0]) - PW'(pp_s2[1]);
			p_s3[1] <= PW'(pp_s2[2]) - PW'(pp_s2[3]);
			p_s3[2] <= PW'(pp_s2[4]) - PW'(pp_s2[5]);
			t_s3   <= t_s2;
			e1_s3  <= e1_s2;
			tag_s3 <= tag_s2;

			// stage 4: det and u terms, t x e1 terms
			for (int i = 0; i < 3; i++) begin
				dp_s4[i] <= DPW'(e1_s3[i]) * DPW'(p_s3[i]);
				up_s4[i] <= DPW'(t_s3[i]) * DPW'(p_s3[i]);
			end
			qp_s4[0] <= QPW'(t_s3[1]) * QPW'(e1_s3[2]);
			qp_s4[1] <= QPW'(t_s3[2]) * QPW'(e1_s3[1]);
			qp_s4[2] <= QPW'(t_s3[2]) * QPW'(e1_s3[0]);
			qp_s4[3] <= QPW'(t_s3[0]) * QPW'(e1_s3[2]);
			qp_s4[4] <= QPW'(t_s3[0]) * QPW'(e1_s3[1]);
			qp_s4[5] <= QPW'(t_s3[1]) * QPW'(e1_s3[0]);
			tag_s4 <= tag_s3;

			// stage 5: det and u sums, q = t x e1
			det_s5  <= W'(dp_s4[0]) + W'(dp_s4[1]) + W'(dp_s4[2]);
			u_s5    <= W'(up_s4[0]) + W'(up_s4[1]) + W'(up_s4[2]);
			q_s5[0] <= QW'(qp_s4[0]) - QW'(qp_s4[1]);
			q_s5[1] <= QW'(qp_s4[2]) - QW'(qp_s4[3]);
			q_s5[2] <= QW'(qp_s4[4]) - QW'(qp_s4[5]);
			tag_s5  <= tag_s4;

			// stage 6: v terms, fold sign of det onto det and u
			for (int i = 0; i < 3; i++) begin
				vp_s6[i] <= DPW'(dir_q[i]) * DPW'(q_s5[i]);
			end
			det_s6  <= det_f;
			u_s6    <= u_f;
			flip_s6 <= flip;
			ok_s6   <= !(det_f < eps_w);
			tag_s6  <= tag_s5;

			// stage 7: v sum, u window
			v_s7   <= flip_s6 ? -v_sum : v_sum;
			det_s7 <= det_s6;
			u_s7   <= u_s6;
			ok_s7  <= ok_s6 && !(u_s6 < eps_w) && !(det_s6 < u_s6);
			tag_s7 <= tag_s6;

			// stage 8: v window and u + v bound
			hit_s8 <= ok_s7 && !(v_s7 < eps_w) && !(det_s7 < (u_s7 + v_s7));
			tag_s8 <= tag_s7;
		end
	end

	// result beat
	assign m_tvalid = vld_s8;
	assign m_tdata  = OUT_BITS'({tag_s8, hit_s8});

	// a beat arriving while the pipeline moves goes straight in, not to the skid
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && en |=> !skid_q)
	else $error("skid loaded while pipeline advanced");

	// a stalled pipeline keeps its last stage
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_s8 && $stable(hit_s8) && $stable(tag_s8))
	else $error("result changed during stall");

	// a triangle rejected before the v test never reports a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s7 && !ok_s7 |=> !hit_s8)
	else $error("hit reported after early reject");

	// the skid entry only fills while the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(!en))
	else $error("skid filled without a stall");

endmodule

[tb/sv/ray_triangle_hit_test_top_tb.sv]
// ---------------------------------------------------------------------------
// ray_triangle_hit_test_top_tb: self-checking bench for the ray / triangle test
// Streams triangles against a series of rays, predicts each hit flag and tag
// with exact integer arithmetic and checks every result beat in order, under
// random source gaps, random sink back-pressure and one long sink hold.
// ---------------------------------------------------------------------------
module ray_triangle_hit_test_top_tb;
	import rth_pkg::*;

	localparam int CB              = RTH_COORD_BITS;
	localparam int S_BITS          = ((9*CB+TAG_BITS+7)/8)*8;
	localparam int PAD_BITS        = CFG_DATA_BITS-CB;
	localparam int PIPE_LAT        = 8;
	localparam int ITEMS_PER_PHASE = 117;
	localparam int LONG_HOLD       = 150;
	localparam int CYCLE_LIMIT     = 400000;

	// index with no register behind it
	localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;

	// one triangle beat; packed so that v0_x lands in the lowest bits
	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic [8:0][CB-1:0]   vtx;
	} tri_t;

	typedef struct packed {
		logic                hit;
		logic [TAG_BITS-1:0] tag;
	} hit_rec_t;

	typedef enum int {
		TRI_AIMED,
		TRI_FLAT,
		TRI_ON_VERTEX,
		TRI_WILD,
		TRI_BROKEN
	} tri_kind_t;

	// predicted hit flags in acceptance order, with a copy of the ray
	class hit_tracker;
		longint   org[3];
		longint   ray_dir[3];
		longint   eps;
		hit_rec_t pending_hits[$];
		int       errors;
		int       n_hit;
		int       n_miss;

		function new();
			org     = '{0, 0, 0};
			ray_dir = '{0, 0, 1};
			eps     = 1;
			errors  = 0;
			n_hit   = 0;
			n_miss  = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
			case (addr)
				REG_ORIGIN_X: org[0]     = longint'($signed(data[CB-1:0]));
				REG_ORIGIN_Y: org[1]     = longint'($signed(data[CB-1:0]));
				REG_ORIGIN_Z: org[2]     = longint'($signed(data[CB-1:0]));
				REG_DIR_X:    ray_dir[0] = longint'($signed(data[CB-1:0]));
				REG_DIR_Y:    ray_dir[1] = longint'($signed(data[CB-1:0]));
				REG_DIR_Z:    ray_dir[2] = longint'($signed(data[CB-1:0]));
				REG_EPSILON:  eps        = longint'(data);
				default: ;
			endcase
		endfunction

		function void cross3(input longint a[3], input longint b[3], output longint c[3]);
			c[0] = a[1]*b[2] - a[2]*b[1];
			c[1] = a[2]*b[0] - a[0]*b[2];
			c[2] = a[0]*b[1] - a[1]*b[0];
		endfunction

		function longint dot3(input longint a[3], input longint b[3]);
			return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
		endfunction

		// moller-trumbore in exact integers; every term fits in 64 bits at 16-bit coords
		function bit ray_meets_tri(tri_t tr);
			longint v0[3], e1[3], e2[3], p[3], t[3], q[3];
			longint det, u, v;
			int     i;
			for (i = 0; i < 3; i++) begin
				v0[i] = longint'($signed(tr.vtx[i]));
				e1[i] = longint'($signed(tr.vtx[3+i])) - v0[i];
				e2[i] = longint'($signed(tr.vtx[6+i])) - v0[i];
			end
			cross3(ray_dir, e2, p);
			det = dot3(e1, p);
			// fold the back-facing case onto a positive determinant
			if (eps < det) begin
				for (i = 0; i < 3; i++) t[i] = org[i] - v0[i];
			end else begin
				for (i = 0; i < 3; i++) t[i] = v0[i] - org[i];
				det = -det;
			end
			if (det < eps) return 1'b0;
			u = dot3(t, p);
			if (u < eps || det < u) return 1'b0;
			cross3(t, e1, q);
			v = dot3(ray_dir, q);
			if (v < eps || det < u + v) return 1'b0;
			return 1'b1;
		endfunction

		function int pending();
			return pending_hits.size();
		endfunction

		function void note_tri(tri_t tr);
			hit_rec_t r;
			r.hit = ray_meets_tri(tr);
			r.tag = tr.tag;
			pending_hits = {pending_hits, r};
		endfunction

		function void check(logic hit, logic [TAG_BITS-1:0] tag);
			hit_rec_t want;
			if (pending_hits.size() == 0) begin
				$error("result beat with no triangle pending: hit %0d tag %h", hit, tag);
				errors++;
				return;
			end
			want = pending_hits.pop_front();
			if (hit !== want.hit) begin
				$error("hit: expected %0d, actual %0d (tag %h)", want.hit, hit, want.tag);
				errors++;
			end
			if (tag !== want.tag) begin
				$error("hit_tag: expected %h, actual %h", want.tag, tag);
				errors++;
			end
			if (hit === 1'b1) n_hit++;
			else n_miss++;
		endfunction
	endclass

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	// s_tdata from bit 0: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, tri_tag
	logic [S_BITS-1:0]        s_tdata   = '0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	// m_tdata from bit 0: hit, hit_tag, zero padding
	logic [OUT_BITS-1:0]      m_tdata;

	hit_tracker tracker = new();

	longint ray_o[3] = '{0, 0, 0};
	longint ray_d[3] = '{0, 0, 1};
	bit     src_gaps  = 1'b1;
	bit     sink_gaps = 1'b1;
	int     hold_reqs = 0;
	int     hold_seen = 0;
	int     hold_left = 0;
	int     n_sent    = 0;
	int     n_rays    = 0;
	int     cycles    = 0;

	ray_triangle_hit_test_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ray_triangle_hit_test_top_tb: FAIL");
			$finish;
		end
	end

	// result side: check taken beats, then pick the next tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check(m_tdata[0], m_tdata[TAG_BITS:1]);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				hold_left = $urandom_range(0, 11);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic longint srnd(int r);
		return longint'($urandom_range(0, 2*r)) - longint'(r);
	endfunction

	function automatic tri_t mk_tri(input int c[9], input int tag);
		tri_t tr;
		int   i;
		for (i = 0; i < 9; i++) tr.vtx[i] = CB'(c[i]);
		tr.tag = TAG_BITS'(tag);
		return tr;
	endfunction

	// random triangle, mostly built around a point on the current ray
	function automatic tri_t make_tri();
		tri_t      tr;
		longint    pt[3], a[3], b[3];
		longint    s;
		int        spread, i, r;
		tri_kind_t kind;
		r = $urandom_range(0, 99);
		if (r < 55) kind = TRI_AIMED;
		else if (r < 63) kind = TRI_FLAT;
		else if (r < 71) kind = TRI_ON_VERTEX;
		else if (r < 86) kind = TRI_WILD;
		else kind = TRI_BROKEN;
		case ($urandom_range(0, 2))
			0: spread = 6;
			1: spread = 250;
			default: spread = 4000;
		endcase
		s = srnd(120);
		for (i = 0; i < 3; i++) begin
			pt[i] = ray_o[i] + s*ray_d[i];
			a[i]  = srnd(spread);
			b[i]  = srnd(spread);
		end
		// centroid close to the ray point
		for (i = 0; i < 3; i++) begin
			tr.vtx[i]   = CB'(pt[i] + a[i]);
			tr.vtx[3+i] = CB'(pt[i] + b[i]);
			tr.vtx[6+i] = CB'(pt[i] - a[i] - b[i] + srnd(2));
		end
		case (kind)
			TRI_FLAT:      for (i = 0; i < 3; i++) tr.vtx[6+i] = tr.vtx[3+i];
			TRI_ON_VERTEX: for (i = 0; i < 3; i++) tr.vtx[i] = CB'(pt[i]);
			TRI_WILD:      for (i = 0; i < 9; i++) tr.vtx[i] = CB'($urandom());
			TRI_BROKEN:    tr.vtx[$urandom_range(0, 8)] = CB'($urandom());
			default: ;
		endcase
		tr.tag = TAG_BITS'($urandom());
		return tr;
	endfunction

	task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		tracker.set_reg(addr, data);
	endtask

	// load a new ray; coordinate writes carry junk above the coordinate width
	task automatic set_ray(input longint o[3], input longint d[3],
			input logic [CFG_DATA_BITS-1:0] e);
		write_reg(REG_ORIGIN_X, {PAD_BITS'($urandom()), CB'(o[0])});
		write_reg(REG_ORIGIN_Y, {PAD_BITS'($urandom()), CB'(o[1])});
		write_reg(REG_ORIGIN_Z, {PAD_BITS'($urandom()), CB'(o[2])});
		write_reg(REG_DIR_X,    {PAD_BITS'($urandom()), CB'(d[0])});
		write_reg(REG_DIR_Y,    {PAD_BITS'($urandom()), CB'(d[1])});
		write_reg(REG_DIR_Z,    {PAD_BITS'($urandom()), CB'(d[2])});
		write_reg(REG_EPSILON,  e);
		write_reg(REG_UNUSED,   CFG_DATA_BITS'({$urandom(), $urandom()}));
		cfg_we <= 1'b0;
		@(posedge clk);
		ray_o = o;
		ray_d = d;
		n_rays++;
	endtask

	// offer one triangle beat and wait until it is taken
	task automatic send_tri(input tri_t tr);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_BITS'(tr);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_tri(tr);
		n_sent++;
	endtask

	// stop sending and let every pending result come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	initial begin
		int k, n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ray: origin 0, direction +z, threshold 1
		send_tri(mk_tri('{-100, -100, 50, 100, -100, 50, 0, 100, 50}, 'h0000));
		send_tri(mk_tri('{-100, -100, 50, 0, 100, 50, 100, -100, 50}, 'hffff));
		send_tri(mk_tri('{900, -100, 50, 1100, -100, 50, 1000, 100, 50}, 'h1234));
		send_tri(mk_tri('{7, 7, 7, 7, 7, 7, 7, 7, 7}, 'h0001));
		send_tri(mk_tri('{-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768}, 'h8000));
		send_tri(mk_tri('{32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767}, 'h7fff));
		send_tri(mk_tri('{32767, 32767, 32767, -32768, -32768, -32768,
			32767, -32768, 0}, 'h5555));
		// vertex on the ray, triangle parallel to the ray, ray through an edge
		send_tri(mk_tri('{0, 0, 10, 100, 0, 10, 0, 100, 10}, 'haaaa));
		send_tri(mk_tri('{0, 0, 0, 0, 0, 100, 100, 0, 0}, 'h00ff));
		send_tri(mk_tri('{-50, 0, 5, 50, 0, 5, 0, 80, 5}, 'hff00));
		settle();

		// zero threshold: boundary cases become hits
		set_ray('{0, 0, 0}, '{0, 0, 1}, '0);
		send_tri(mk_tri('{0, 0, 10, 100, 0, 10, 0, 100, 10}, 'h0f0f));
		send_tri(mk_tri('{7, 7, 7, 7, 7, 7, 7, 7, 7}, 'hf0f0));
		send_tri(mk_tri('{-50, 0, 5, 50, 0, 5, 0, 80, 5}, 'h3c3c));
		send_tri(mk_tri('{2000, 2000, 5, 2100, 2000, 5, 2000, 2100, 5}, 'hc3c3));
		settle();

		// largest threshold with a full-range ray and triangle
		set_ray('{0, 0, -32768}, '{0, 0, 32767}, '1);
		send_tri(mk_tri('{-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0}, 'h6666));
		send_tri(mk_tri('{-10, -10, 0, 10, -10, 0, 0, 10, 0}, 'h9999));
		settle();

		// random phases, each under its own ray
		for (k = 1; k <= 8; k++) begin
			case (k)
				1: set_ray('{srnd(2000), srnd(2000), srnd(2000)},
					'{srnd(100), srnd(100), srnd(100)}, CFG_DATA_BITS'(1));
				2: set_ray('{srnd(2000), srnd(2000), srnd(2000)},
					'{srnd(100), srnd(100), srnd(100)}, '0);
				3: set_ray('{srnd(2000), srnd(2000), srnd(2000)},
					'{srnd(32767), srnd(32767), srnd(32767)}, '1);
				4: set_ray('{32767, -32768, -32768}, '{-32768, 32767, 32767},
					CFG_DATA_BITS'($urandom()));
				5: set_ray('{srnd(500), srnd(500), srnd(500)}, '{0, 0, 0}, '0);
				6: set_ray('{srnd(3000), srnd(3000), srnd(3000)},
					'{srnd(300), srnd(300), srnd(300)},
					CFG_DATA_BITS'($urandom_range(0, 1 << 20)));
				7: set_ray('{srnd(32767), srnd(32767), srnd(32767)},
					'{srnd(32767), srnd(32767), srnd(32767)},
					CFG_DATA_BITS'({$urandom(), $urandom()}));
				default: set_ray('{srnd(1000), srnd(1000), srnd(1000)},
					'{srnd(60), srnd(60), srnd(60)}, CFG_DATA_BITS'(1));
			endcase
			// last phase runs at full rate on both sides
			src_gaps  = (k != 8);
			sink_gaps = (k != 8);
			// long sink hold while the source keeps offering
			if (k == 2) hold_reqs++;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (k == 4 && n == 50) settle();
				send_tri(make_tri());
			end
			settle();
		end

		$display("covered %0d triangles under %0d ray settings, long sink hold included",
			n_sent, n_rays + 1);
		$display("saw %0d hits and %0d misses, %0d mismatches",
			tracker.n_hit, tracker.n_miss, tracker.errors);
		if (tracker.errors == 0) begin
			$display("ray_triangle_hit_test_top_tb: PASS");
		end else begin
			$display("ray_triangle_hit_test_top_tb: FAIL");
		end
		$finish;
	end

endmodule

[ray_triangle_hit_test_top.f]
sv/rth_pkg.sv
sv/ray_triangle_hit_test_top.sv
tb/sv/ray_triangle_hit_test_top_tb.sv
